/* hdl/table_linear_interpolator_top_assert.svh */
// Assertion macros for the table interpolator
`ifndef TABLE_LINEAR_INTERPOLATOR_TOP_ASSERT_SVH
`define TABLE_LINEAR_INTERPOLATOR_TOP_ASSERT_SVH
// Implication checked on every clock edge outside reset
`define TLI_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication
`define TLI_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

/* hdl/tli_pkg.sv */
// Shared types and constants for the table interpolator
package tli_pkg;
    localparam int TableDepth = 64;
    localparam int IdxW = $clog2(TableDepth);
    localparam int CntW = IdxW + 1;

    localparam logic [2:0] ST_EXACT  = 3'd0;
    localparam logic [2:0] ST_INTERP = 3'd1;
    localparam logic [2:0] ST_CLIP   = 3'd2;
    localparam logic [2:0] ST_EXTRAP = 3'd3;
    localparam logic [2:0] ST_ERROR  = 3'd4;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [0:0] REG_TABLE_SIZE = 1'd0;
    localparam logic [0:0] REG_CLIP       = 1'd1;

    typedef enum logic [2:0] {
        DC_NONE, DC_READ, DC_LOAD_LO, DC_LOAD_HI, DC_MUL, DC_DIV_START, DC_DIV_STEP, DC_FINISH
    } t_dp_cmd;

    typedef struct packed {
        t_dp_cmd           cmd;
        logic [IdxW-1:0]   addr;
    } t_ctrl;

    typedef struct packed {
        logic signed [31:0] rd_x;
        logic               div_done;
        logic               den_zero;
    } t_stat;
endpackage

/* hdl/tli_datapath.sv */
// Table memory, multiplier, serial divider and result formatting
module tli_datapath import tli_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_wr_en,
    input  logic [IdxW-1:0]    i_wr_idx,
    input  logic signed [31:0] i_wr_x,
    input  logic signed [31:0] i_wr_y,
    input  logic signed [31:0] i_qx,
    input  t_ctrl              i_ctrl,
    output t_stat              o_stat,
    output logic signed [31:0] o_rd_y,
    output logic signed [31:0] o_y,
    output logic               o_sat
);
    logic signed [31:0] r_xmem [TableDepth];
    logic signed [31:0] r_ymem [TableDepth];
    logic signed [31:0] r_rx, r_ry, r_xl, r_yl;
    logic [32:0]  r_mdy, r_mdx, r_mden;
    logic         r_neg;
    logic         r_den_zero;
    logic [65:0]  r_prod;
    logic [65:0]  r_rem;
    logic [65:0]  r_q;
    logic [6:0]   r_cnt;
    logic signed [31:0] r_y;
    logic         r_sat;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_xmem[i_wr_idx] <= i_wr_x;
            r_ymem[i_wr_idx] <= i_wr_y;
        end
        r_rx <= r_xmem[i_ctrl.addr];
        r_ry <= r_ymem[i_ctrl.addr];
    end

    logic signed [32:0] dy, dx, den;
    logic [33:0] trial;
    logic signed [35:0] sum;
    always_comb begin
        dy  = 33'(r_ry) - 33'(r_yl);
        dx  = 33'(i_qx) - 33'(r_xl);
        den = 33'(r_rx) - 33'(r_xl);
        trial = {r_rem[32:0], r_q[65]} - {1'b0, r_mden};
        sum = r_neg ? 36'(r_yl) - 36'(r_q[33:0]) : 36'(r_yl) + 36'(r_q[33:0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            case (i_ctrl.cmd)
                DC_LOAD_LO: begin
                    r_xl <= r_rx;
                    r_yl <= r_ry;
                end
                DC_LOAD_HI: begin
                    r_mdy  <= dy[32] ? 33'(-dy) : 33'(dy);
                    r_mdx  <= dx[32] ? 33'(-dx) : 33'(dx);
                    r_mden <= den[32] ? 33'(-den) : 33'(den);
                    r_neg  <= (dy[32] ^ dx[32]) ^ den[32];
                    r_den_zero <= (den == '0);
                end
                DC_MUL: r_prod <= 66'(r_mdy) * 66'(r_mdx);
                DC_DIV_START: begin
                    r_q   <= r_prod;
                    r_rem <= '0;
                    r_cnt <= 7'd66;
                end
                DC_DIV_STEP: begin
                    if (!trial[33]) begin
                        r_rem <= 66'(trial[32:0]);
                        r_q   <= {r_q[64:0], 1'b1};
                    end else begin
                        r_rem <= {r_rem[64:0], r_q[65]};
                        r_q   <= {r_q[64:0], 1'b0};
                    end
                    r_cnt <= r_cnt - 7'd1;
                end
                DC_FINISH: begin
                    if (r_q[65:34] != '0) begin
                        r_sat <= 1'b1;
                        r_y   <= r_neg ? 32'sh8000_0000 : 32'sh7fff_ffff;
                    end else if (sum > 36'sd2147483647) begin
                        r_sat <= 1'b1;
                        r_y   <= 32'sh7fff_ffff;
                    end else if (sum < -36'sd2147483648) begin
                        r_sat <= 1'b1;
                        r_y   <= 32'sh8000_0000;
                    end else begin
                        r_sat <= 1'b0;
                        r_y   <= sum[31:0];
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_stat.rd_x     = r_rx;
    assign o_stat.div_done = (r_cnt == 7'd1);
    assign o_stat.den_zero = r_den_zero;
    assign o_rd_y = r_ry;
    assign o_y    = r_y;
    assign o_sat  = r_sat;
endmodule

/* hdl/tli_ctrl.sv */
// Search and sequencing controller
module tli_ctrl import tli_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_op,
    input  logic signed [31:0] i_qx,
    input  logic [6:0]         i_table_size,
    input  logic               i_clip,
    input  t_stat              i_stat,
    input  logic signed [31:0] i_rd_y,
    input  logic signed [31:0] i_dp_y,
    input  logic               i_dp_sat,
    input  logic               i_out_stall,
    output logic               o_stall,
    output logic               o_qx_en,
    output t_ctrl              o_ctrl,
    output logic               o_valid,
    output logic signed [31:0] o_y_value,
    output logic [2:0]         o_status,
    output logic               o_saturated
);
    typedef enum logic [3:0] {
        S_IDLE, S_PROBE, S_CMP, S_PICK, S_RDLO, S_RDHI, S_HI, S_MUL, S_DSTART,
        S_DIV, S_FIN, S_OUT, S_RDEND, S_ENDY
    } t_state;

    t_state r_state;
    logic [CntW:0] r_low, r_high, r_lo;
    logic [CntW-1:0] r_n;
    logic [2:0] r_stat;
    logic r_busy_q;
    logic signed [31:0] r_y;
    logic [2:0] r_status;
    logic r_sat, r_ovalid;
    logic signed [31:0] r_oy;
    logic [2:0] r_ostatus;
    logic r_osat;
    t_dp_cmd r_cmd;
    logic [IdxW-1:0] r_addr;

    logic [CntW:0] mid;
    logic [CntW-1:0] n_cap;
    assign mid   = r_low + ((r_high - r_low) >> 1);
    assign n_cap = (i_table_size > 7'(TableDepth)) ? CntW'(TableDepth) : CntW'(i_table_size);

    assign o_stall = (r_state != S_IDLE);
    assign o_qx_en = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_cmd    <= DC_NONE;
        end else begin
            r_cmd <= DC_NONE;
            if (r_ovalid && !i_out_stall) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: if (o_qx_en && i_op == OP_QUERY) begin
                    r_n <= n_cap;
                    if (n_cap == '0) begin
                        r_y <= '0; r_status <= ST_ERROR; r_sat <= 1'b0;
                        r_state <= S_OUT;
                    end else begin
                        r_low  <= '0;
                        r_high <= (CntW+1)'(n_cap) - 1'b1;
                        r_state <= S_PROBE;
                    end
                end
                S_PROBE: begin
                    if ($signed(r_low) <= $signed(r_high)) begin
                        r_addr <= mid[IdxW-1:0];
                        r_cmd  <= DC_READ;
                        r_state <= S_CMP;
                    end else r_state <= S_PICK;
                end
                S_CMP: if (r_cmd == DC_NONE) begin
                    if (i_stat.rd_x < i_qx) begin
                        r_low <= mid + 1'b1; r_state <= S_PROBE;
                    end else if (i_stat.rd_x > i_qx) begin
                        r_high <= mid - 1'b1; r_state <= S_PROBE;
                    end else begin
                        r_y <= i_rd_y; r_status <= ST_EXACT; r_sat <= 1'b0;
                        r_state <= S_OUT;
                    end
                end
                S_PICK: begin
                    if (r_low == '0 || r_low == (CntW+1)'(r_n)) begin
                        if (i_clip) begin
                            r_addr <= (r_low == '0) ? '0 : IdxW'(r_n - 1'b1);
                            r_cmd <= DC_READ;
                            r_state <= S_RDEND;
                        end else if (r_n < 2) begin
                            r_y <= '0; r_status <= ST_ERROR; r_sat <= 1'b0;
                            r_state <= S_OUT;
                        end else begin
                            r_lo <= (r_low == '0) ? '0 : (CntW+1)'(r_n) - 2'd2;
                            r_stat <= ST_EXTRAP;
                            r_state <= S_RDLO;
                        end
                    end else begin
                        r_lo <= r_low - 1'b1; r_stat <= ST_INTERP;
                        r_state <= S_RDLO;
                    end
                end
                S_RDEND: if (r_cmd == DC_NONE) r_state <= S_ENDY;
                S_ENDY: begin
                    r_y <= i_rd_y; r_status <= ST_CLIP; r_sat <= 1'b0;
                    r_state <= S_OUT;
                end
                S_RDLO: begin
                    r_addr <= r_lo[IdxW-1:0]; r_cmd <= DC_READ; r_state <= S_RDHI;
                end
                S_RDHI: if (r_cmd == DC_NONE) begin
                    r_cmd <= DC_LOAD_LO;
                    r_addr <= IdxW'(r_lo + 1'b1);
                    r_state <= S_HI;
                end
                S_HI: if (r_cmd == DC_NONE) begin
                    r_cmd <= DC_LOAD_HI; r_state <= S_MUL;
                end
                S_MUL: begin
                    if (r_cmd != DC_LOAD_HI) begin
                        r_cmd <= DC_MUL; r_state <= S_DSTART;
                    end
                end
                S_DSTART: begin
                    r_cmd <= DC_DIV_START; r_state <= S_DIV;
                end
                S_DIV: begin
                    if (r_cmd == DC_DIV_STEP && i_stat.div_done) begin
                        r_cmd <= DC_FINISH; r_state <= S_FIN;
                    end else r_cmd <= DC_DIV_STEP;
                end
                S_FIN: if (r_cmd == DC_NONE) begin
                    if (i_stat.den_zero) begin
                        r_y <= '0; r_status <= ST_ERROR; r_sat <= 1'b0;
                    end else begin
                        r_y <= i_dp_y; r_status <= r_stat; r_sat <= i_dp_sat;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: if (!r_ovalid) begin
                    r_ovalid  <= 1'b1;
                    r_oy      <= r_y;
                    r_ostatus <= r_status;
                    r_osat    <= r_sat;
                    r_state   <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign r_busy_q = 1'b0;
    assign o_ctrl.cmd  = r_cmd;
    assign o_ctrl.addr = r_addr;
    assign o_valid     = r_ovalid | r_busy_q;
    assign o_y_value   = r_oy;
    assign o_status    = r_ostatus;
    assign o_saturated = r_osat;

`include "table_linear_interpolator_top_assert.svh"
    `TLI_ASSERT_IMP(a_err_zero, i_clk, i_rst_n, o_valid && o_status == ST_ERROR, o_y_value == 0 && !o_saturated)
    `TLI_ASSERT_IMP(a_busy_stall, i_clk, i_rst_n, r_state != S_IDLE, o_stall)
    `TLI_ASSERT_NXT(a_hold_out, i_clk, i_rst_n, o_valid && i_out_stall, o_valid && $stable(o_y_value))
endmodule

/* hdl/table_linear_interpolator_top.sv */
// Top level of the piecewise linear interpolation table
// A load word is taken and gives no result. A query runs a binary search with
// one registered memory read per probe (at most seven probes over 64 entries),
// then two reads, one 33x33 multiply and a restoring division that develops a
// 66-bit quotient before an interpolated or extrapolated result is given; an
// exact match or a clipped result skips the multiply and the division. Errors
// come before any multiply, or after the full division when both neighbors
// share one x. One query is computed at a time; a finished result waits in an
// output register, so the next word is taken while it is stalled.
module table_linear_interpolator_top import tli_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [0:0]         i_cfg_idx,
    input  logic [6:0]         i_cfg_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_op,
    input  logic [5:0]         i_entry_index,
    input  logic signed [31:0] i_entry_x,
    input  logic signed [31:0] i_entry_y,
    input  logic signed [31:0] i_query_x,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_y_value,
    output logic [2:0]         o_status,
    output logic               o_saturated
);
    logic [6:0] r_table_size;
    logic r_clip;
    logic signed [31:0] r_qx;
    logic qx_en;
    t_ctrl ctrl;
    t_stat stat;
    logic signed [31:0] rd_y, dp_y;
    logic dp_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_size <= '0;
            r_clip <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_TABLE_SIZE: r_table_size <= i_cfg_data;
                REG_CLIP:       r_clip <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (qx_en) r_qx <= i_query_x;
    end

    tli_datapath u_dp (
        .i_clk, .i_rst_n,
        .i_wr_en(qx_en && i_op == OP_LOAD), .i_wr_idx(i_entry_index),
        .i_wr_x(i_entry_x), .i_wr_y(i_entry_y), .i_qx(r_qx),
        .i_ctrl(ctrl), .o_stat(stat), .o_rd_y(rd_y), .o_y(dp_y), .o_sat(dp_sat)
    );

    tli_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .i_op, .i_qx(r_qx),
        .i_table_size(r_table_size), .i_clip(r_clip), .i_stat(stat), .i_rd_y(rd_y),
        .i_dp_y(dp_y), .i_dp_sat(dp_sat), .i_out_stall(i_stall), .o_stall,
        .o_qx_en(qx_en), .o_ctrl(ctrl), .o_valid, .o_y_value, .o_status, .o_saturated
    );
endmodule
